// ===== hdl/midi_event_stream_parser_top_macros.svh =====
// Assertion macros for the MIDI event stream parser.
// Used by files that check their own logic; no other dependencies.
`ifndef MIDI_EVENT_STREAM_PARSER_TOP_MACROS_SVH
`define MIDI_EVENT_STREAM_PARSER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define MESP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the following cycle
`define MESP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mesp_pkg.sv =====
// Shared types and constants for the MIDI event stream parser.
// No dependencies; used by the stream and result interfaces and all modules.
`default_nettype none
package mesp_pkg;

	localparam int TABLE_DEPTH_DEF = 128;
	localparam int TIDX_W          = 7;
	localparam int TENTRY_W        = 16;
	localparam int DELTA_W         = 32;

	localparam logic [7:0] STATUS_META = 8'hFF;
	localparam logic [7:0] META_EOT    = 8'h2F;

	localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
	localparam logic [3:0] HI_NOTE_ON   = 4'h9;
	localparam logic [3:0] HI_POLY      = 4'hA;
	localparam logic [3:0] HI_CTRL      = 4'hB;
	localparam logic [3:0] HI_PROG      = 4'hC;
	localparam logic [3:0] HI_CHAN_PRES = 4'hD;
	localparam logic [3:0] HI_BEND      = 4'hE;
	localparam logic [3:0] HI_SYSTEM    = 4'hF;

	typedef enum logic [1:0] {
		OP_BYTE    = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_CHAN      = 2'd0,
		KIND_META_HDR  = 2'd1,
		KIND_META_DATA = 2'd2,
		KIND_ERROR     = 2'd3
	} kind_t;

	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_NOT_RUNNING = 2'd1;
	localparam logic [1:0] ERR_BAD_DATA    = 2'd2;

	typedef struct packed {
		logic                 valid;
		kind_t                kind;
		logic [7:0]           status;
		logic [7:0]           data1;
		logic [7:0]           data2;
		logic [1:0]           data_count;
		logic [DELTA_W-1:0]   delta_time;
		logic                 last;
		logic                 end_of_track;
		logic [1:0]           error_code;
		logic                 use_table;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/mesp_if.sv =====
// Channel interfaces: stream input, result output and configuration write.
// Depends on mesp_pkg for field widths.
`default_nettype none
interface mesp_in_if import mesp_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [7:0]        byte_value;
	logic [TIDX_W-1:0] table_index;
	logic [7:0]        table_status;
	logic [7:0]        table_note;

	modport source (output valid, opcode, byte_value, table_index, table_status, table_note,
		input ready);
	modport sink (input valid, opcode, byte_value, table_index, table_status, table_note,
		output ready);
endinterface

interface mesp_out_if import mesp_pkg::*; ;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         status;
	logic [7:0]         data1;
	logic [7:0]         data2;
	logic [1:0]         data_count;
	logic [DELTA_W-1:0] delta_time;
	logic               last;
	logic               end_of_track;
	logic [1:0]         error_code;

	modport source (output valid, kind, status, data1, data2, data_count, delta_time, last,
		end_of_track, error_code, input ready);
	modport sink (input valid, kind, status, data1, data2, data_count, delta_time, last,
		end_of_track, error_code, output ready);
endinterface

interface mesp_cfg_if;
	logic valid;
	logic ready;
	logic comp_mode;

	modport source (output valid, comp_mode, input ready);
	modport sink (input valid, comp_mode, output ready);
endinterface
`default_nettype wire

// ===== hdl/mesp_table.sv =====
// Compression table: single-port-write, registered-read memory of (status, note).
// Depends on mesp_pkg.
`default_nettype none
module mesp_table import mesp_pkg::*; #(
	parameter int DEPTH = TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire logic [TENTRY_W-1:0] wdata,
	input  wire logic                re,
	input  wire logic [AW-1:0]       raddr,
	output logic      [TENTRY_W-1:0] rdata
);

	logic [TENTRY_W-1:0] mem_q [DEPTH];
	logic [TENTRY_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/mesp_parser.sv =====
// Byte-serial phase machine: decodes delta, status and data bytes into result items.
// Depends on mesp_pkg; drives the table read address for compressed poly pressure.
`default_nettype none
module mesp_parser import mesp_pkg::*; #(
	parameter int AW = TIDX_W
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        acc,
	input  wire logic        adv,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  byte_value,
	input  wire logic        comp_mode,
	output logic [AW-1:0]    rd_addr,
	output res_t             res_s1
);

	typedef enum logic [2:0] {
		PH_DELTA     = 3'd0,
		PH_STATUS    = 3'd1,
		PH_ONE       = 3'd2,
		PH_TWO_A     = 3'd3,
		PH_TWO_B     = 3'd4,
		PH_META_TYPE = 3'd5,
		PH_META_LEN  = 3'd6,
		PH_META_DATA = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		RUN_OK  = 2'd0,
		RUN_EOT = 2'd1,
		RUN_ERR = 2'd2
	} run_t;

	run_t               run_q, run_d;
	phase_t             phase_q, phase_d;
	logic [DELTA_W-1:0] delta_q, delta_d;
	logic [7:0]         rs_q, rs_d;
	logic [7:0]         held_q, held_d;
	logic [7:0]         rem_q, rem_d;
	res_t               res_d;

	always_comb begin
		logic [7:0] b;
		logic [7:0] st;
		logic [7:0] rem_m1;
		phase_t     eph;
		phase_t     fin_ph;
		logic       bad;
		logic       do_data;

		b       = byte_value;
		run_d   = run_q;
		phase_d = phase_q;
		delta_d = delta_q;
		rs_d    = rs_q;
		held_d  = held_q;
		rem_d   = rem_q;
		res_d   = '0;
		st      = (phase_q == PH_STATUS && b[7]) ? b : rs_q;
		rem_m1  = rem_q - 8'd1;
		eph     = phase_q;
		bad     = 1'b0;
		do_data = 1'b0;
		fin_ph  = (b[7] && st != STATUS_META) ? PH_STATUS : PH_DELTA;
		rd_addr = AW'({b[6:4], st[3:0]});

		if (acc) begin
			case (op_t'(opcode))
				OP_BYTE: begin
					if (run_q != RUN_OK) begin
						res_d.valid      = 1'b1;
						res_d.kind       = KIND_ERROR;
						res_d.last       = 1'b1;
						res_d.error_code = ERR_NOT_RUNNING;
					end else if (phase_q == PH_DELTA) begin
						delta_d = {delta_q[DELTA_W-8:0], 7'd0} + DELTA_W'(b[6:0]);
						if (!b[7]) begin
							phase_d = PH_STATUS;
						end
					end else begin
						do_data = 1'b1;
						if (phase_q == PH_STATUS) begin
							rs_d = st;
							case (st[7:4])
								HI_NOTE_OFF, HI_PROG, HI_CHAN_PRES: eph = PH_ONE;
								HI_POLY: eph = comp_mode ? PH_ONE : PH_TWO_A;
								HI_NOTE_ON, HI_CTRL, HI_BEND: eph = PH_TWO_A;
								HI_SYSTEM: begin
									if (st == STATUS_META) begin
										eph = PH_META_TYPE;
									end else begin
										bad = 1'b1;
									end
								end
								default: bad = 1'b1;
							endcase
							if (bad) begin
								do_data          = 1'b0;
								run_d            = RUN_ERR;
								res_d.valid      = 1'b1;
								res_d.kind       = KIND_ERROR;
								res_d.last       = 1'b1;
								res_d.error_code = ERR_BAD_DATA;
							end else if (b[7]) begin
								do_data = 1'b0;
								phase_d = eph;
							end
						end
						if (do_data) begin
							res_d.delta_time = delta_q;
							res_d.last       = 1'b1;
							case (eph)
								PH_ONE: begin
									res_d.valid = 1'b1;
									res_d.kind  = KIND_CHAN;
									res_d.data_count = (st[7:4] == HI_POLY) ? 2'd2 : 2'd1;
									if (st[7:4] == HI_POLY) begin
										res_d.use_table = 1'b1;
										res_d.data2     = {1'b0, b[3:0], 3'd0};
									end else begin
										res_d.status = st;
										res_d.data1  = {1'b0, b[6:0]};
									end
									phase_d = fin_ph;
									delta_d = '0;
								end
								PH_TWO_A: begin
									held_d  = b;
									phase_d = PH_TWO_B;
								end
								PH_TWO_B: begin
									res_d.valid      = 1'b1;
									res_d.kind       = KIND_CHAN;
									res_d.status     = st;
									res_d.data1      = held_q;
									res_d.data2      = {1'b0, b[6:0]};
									res_d.data_count = 2'd2;
									phase_d          = fin_ph;
									delta_d          = '0;
								end
								PH_META_TYPE: begin
									held_d  = b;
									phase_d = PH_META_LEN;
								end
								PH_META_LEN: begin
									res_d.valid  = 1'b1;
									res_d.kind   = KIND_META_HDR;
									res_d.status = STATUS_META;
									res_d.data1  = held_q;
									res_d.data2  = b;
									res_d.last   = (b == 8'd0);
									res_d.end_of_track = (held_q == META_EOT) && (b == 8'd0);
									rem_d = b;
									if (b == 8'd0) begin
										if (held_q == META_EOT) begin
											run_d = RUN_EOT;
										end
										phase_d = PH_DELTA;
										delta_d = '0;
									end else begin
										phase_d = PH_META_DATA;
									end
								end
								PH_META_DATA: begin
									res_d.valid  = 1'b1;
									res_d.kind   = KIND_META_DATA;
									res_d.status = STATUS_META;
									res_d.data1  = b;
									res_d.last   = (rem_m1 == 8'd0);
									rem_d        = rem_m1;
									if (rem_m1 == 8'd0) begin
										phase_d = PH_DELTA;
										delta_d = '0;
									end
								end
								default: begin
									res_d.valid = 1'b0;
								end
							endcase
						end
					end
				end
				OP_RESTART: begin
					run_d   = RUN_OK;
					phase_d = PH_DELTA;
					delta_d = '0;
					rs_d    = '0;
					held_d  = '0;
					rem_d   = '0;
				end
				default: begin
					res_d.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= RUN_OK;
			phase_q <= PH_DELTA;
			delta_q <= '0;
			rs_q    <= '0;
			held_q  <= '0;
			rem_q   <= '0;
			res_s1  <= '0;
		end else begin
			run_q   <= run_d;
			phase_q <= phase_d;
			delta_q <= delta_d;
			rs_q    <= rs_d;
			held_q  <= held_d;
			rem_q   <= rem_d;
			if (adv) begin
				res_s1 <= res_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/midi_event_stream_parser_top.sv =====
// Pipeline: the byte that completes an event is registered as an item in res_s1, then in res_q.
// Throughput: one item (stream byte, table load or restart) per cycle while the output
// register is empty or events.ready is high; a stall holds stream.ready low.
// Reset: arst_n clears parser state, comp_mode and the pipeline; table contents are
// undefined until loaded.
`default_nettype none
module midi_event_stream_parser_top import mesp_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mesp_in_if.sink   stream,
	mesp_out_if.source events,
	mesp_cfg_if.sink  cfg
);

`include "midi_event_stream_parser_top_macros.svh"

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                comp_mode_q;
	logic                adv;
	logic                acc;
	logic [AW-1:0]       rd_addr;
	logic [TENTRY_W-1:0] rd_data;
	res_t                res_s1;
	res_t                res_nx;
	res_t                res_q;

	assign adv          = !res_q.valid || events.ready;
	assign stream.ready = adv;
	assign acc          = stream.valid && adv;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			comp_mode_q <= cfg.comp_mode;
		end
	end

	mesp_parser #(.AW(AW)) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.adv        (adv),
		.opcode     (stream.opcode),
		.byte_value (stream.byte_value),
		.comp_mode  (comp_mode_q),
		.rd_addr    (rd_addr),
		.res_s1     (res_s1)
	);

	mesp_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
		.clk   (clk),
		.we    (acc && op_t'(stream.opcode) == OP_LOAD),
		.waddr (AW'(stream.table_index)),
		.wdata ({stream.table_status, stream.table_note}),
		.re    (adv),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// table lookup merges into the item here
	always_comb begin
		res_nx = res_s1;
		if (res_s1.use_table) begin
			res_nx.status = rd_data[15:8];
			res_nx.data1  = rd_data[7:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (adv) begin
			res_q <= res_nx;
		end
	end

	assign events.valid        = res_q.valid;
	assign events.kind         = res_q.kind;
	assign events.status       = res_q.status;
	assign events.data1        = res_q.data1;
	assign events.data2        = res_q.data2;
	assign events.data_count   = res_q.data_count;
	assign events.delta_time   = res_q.delta_time;
	assign events.last         = res_q.last;
	assign events.end_of_track = res_q.end_of_track;
	assign events.error_code   = res_q.error_code;

	`MESP_ASSERT_IMPL(a_err_last, clk, arst_n,
		res_q.valid && res_q.kind == KIND_ERROR,
		res_q.last && res_q.error_code != ERR_NONE, "error item must be last with a code")
	`MESP_ASSERT_IMPL(a_eot_hdr, clk, arst_n, res_q.valid && res_q.end_of_track,
		res_q.kind == KIND_META_HDR && res_q.last, "end of track only on a final meta header")
	`MESP_ASSERT_IMPL(a_chan_cnt, clk, arst_n, res_q.valid && res_q.kind == KIND_CHAN,
		res_q.data_count != 2'd0 && res_q.data_count != 2'd3,
		"channel item needs one or two data bytes")
	`MESP_ASSERT_NEXT(a_s1_hold, clk, arst_n, res_s1.valid && !adv, res_s1.valid,
		"stage one item lost during stall")

endmodule
`default_nettype wire
